[rtl/kehid_pkg.sv]
// ----------------------------------------------------------------------------
// kehid_pkg
// Shared types, constants and the key-code to HID-usage lookup table.
// ----------------------------------------------------------------------------
package kehid_pkg;

  // Number of key slots held in the report state.
  localparam int unsigned KEY_SLOTS   = 6;
  // Key fields carried by one report.
  localparam int unsigned REPORT_KEYS = 6;
  // Slots that show up in a report.
  localparam int unsigned SHOWN_SLOTS = (KEY_SLOTS < REPORT_KEYS) ? KEY_SLOTS : REPORT_KEYS;

  localparam int unsigned CODE_W   = 10;
  localparam int unsigned VALUE_W  = 2;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned WINDOW_W = 16;
  localparam int unsigned USAGE_W  = 8;

  // Input tdata: key_code, event_time_ms, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = 48;
  // Output tdata: modifier_bits, key_0 .. key_5.
  localparam int unsigned OUT_DATA_W = USAGE_W * (REPORT_KEYS + 1);

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_TAP_WINDOW = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOTKEY     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PRESENT    = 2'd2;

  // Key event values.
  localparam logic [VALUE_W-1:0] KEY_RELEASE = 2'd0;
  localparam logic [VALUE_W-1:0] KEY_PRESS   = 2'd1;
  localparam logic [VALUE_W-1:0] KEY_REPEAT  = 2'd2;

  // Report kinds.
  localparam logic REPORT_KEY         = 1'b0;
  localparam logic REPORT_RELEASE_ALL = 1'b1;

  // Modifier usages occupy 0xE0 .. 0xE7.
  localparam logic [4:0] MOD_USAGE_HI = 5'b11100;

  localparam logic [WINDOW_W-1:0] TAP_WINDOW_RST = 16'd400;
  localparam logic [CODE_W-1:0]   HOTKEY_RST     = 10'd70;
  localparam logic [1:0]          PRESENT_RST    = 2'b11;

  typedef enum logic [2:0] {
    PHASE_IDLE = 3'b001,
    PHASE_DOWN = 3'b010,
    PHASE_UP   = 3'b100
  } phase_e;

  typedef logic [USAGE_W-1:0] usage_t;

  // Linux key code (below 256) to USB HID keyboard usage, 0 when unmapped.
  function automatic usage_t usage_of_code(input logic [7:0] code);
    usage_t u;
    u = 8'h00;
    case (code)
      8'd1:   u = 8'h29;
      8'd2:   u = 8'h1E;  8'd3:   u = 8'h1F;  8'd4:   u = 8'h20;  8'd5:   u = 8'h21;
      8'd6:   u = 8'h22;  8'd7:   u = 8'h23;  8'd8:   u = 8'h24;  8'd9:   u = 8'h25;
      8'd10:  u = 8'h26;  8'd11:  u = 8'h27;
      8'd12:  u = 8'h2D;  8'd13:  u = 8'h2E;  8'd14:  u = 8'h2A;  8'd15:  u = 8'h2B;
      8'd16:  u = 8'h14;  8'd17:  u = 8'h1A;  8'd18:  u = 8'h08;  8'd19:  u = 8'h15;
      8'd20:  u = 8'h17;  8'd21:  u = 8'h1C;  8'd22:  u = 8'h18;  8'd23:  u = 8'h0C;
      8'd24:  u = 8'h12;  8'd25:  u = 8'h13;
      8'd26:  u = 8'h2F;  8'd27:  u = 8'h30;  8'd28:  u = 8'h28;  8'd29:  u = 8'hE0;
      8'd30:  u = 8'h04;  8'd31:  u = 8'h16;  8'd32:  u = 8'h07;  8'd33:  u = 8'h09;
      8'd34:  u = 8'h0A;  8'd35:  u = 8'h0B;  8'd36:  u = 8'h0D;  8'd37:  u = 8'h0E;
      8'd38:  u = 8'h0F;
      8'd39:  u = 8'h33;  8'd40:  u = 8'h34;  8'd41:  u = 8'h35;  8'd42:  u = 8'hE1;
      8'd43:  u = 8'h31;
      8'd44:  u = 8'h1D;  8'd45:  u = 8'h1B;  8'd46:  u = 8'h06;  8'd47:  u = 8'h19;
      8'd48:  u = 8'h05;  8'd49:  u = 8'h11;  8'd50:  u = 8'h10;
      8'd51:  u = 8'h36;  8'd52:  u = 8'h37;  8'd53:  u = 8'h38;  8'd54:  u = 8'hE5;
      8'd55:  u = 8'h55;  8'd56:  u = 8'hE2;  8'd57:  u = 8'h2C;  8'd58:  u = 8'h39;
      8'd59:  u = 8'h3A;  8'd60:  u = 8'h3B;  8'd61:  u = 8'h3C;  8'd62:  u = 8'h3D;
      8'd63:  u = 8'h3E;  8'd64:  u = 8'h3F;  8'd65:  u = 8'h40;  8'd66:  u = 8'h41;
      8'd67:  u = 8'h42;  8'd68:  u = 8'h43;
      8'd69:  u = 8'h53;  8'd70:  u = 8'h47;
      8'd71:  u = 8'h5F;  8'd72:  u = 8'h60;  8'd73:  u = 8'h61;  8'd74:  u = 8'h56;
      8'd75:  u = 8'h5C;  8'd76:  u = 8'h5D;  8'd77:  u = 8'h5E;  8'd78:  u = 8'h57;
      8'd79:  u = 8'h59;  8'd80:  u = 8'h5A;
      8'd81:  u = 8'h5B;  8'd82:  u = 8'h62;  8'd83:  u = 8'h63;
      8'd87:  u = 8'h44;  8'd88:  u = 8'h45;
      8'd96:  u = 8'h58;  8'd97:  u = 8'hE4;  8'd98:  u = 8'h54;  8'd99:  u = 8'h46;
      8'd100: u = 8'hE6;
      8'd102: u = 8'h4A;  8'd103: u = 8'h52;  8'd104: u = 8'h4B;  8'd105: u = 8'h50;
      8'd106: u = 8'h4F;  8'd107: u = 8'h4D;  8'd108: u = 8'h51;  8'd109: u = 8'h4E;
      8'd110: u = 8'h49;  8'd111: u = 8'h4C;
      8'd119: u = 8'h48;
      8'd125: u = 8'hE3;  8'd126: u = 8'hE7;  8'd127: u = 8'h65;
      8'd183: u = 8'h68;  8'd184: u = 8'h69;  8'd185: u = 8'h6A;  8'd186: u = 8'h6B;
      8'd187: u = 8'h6C;  8'd188: u = 8'h6D;  8'd189: u = 8'h6E;  8'd190: u = 8'h6F;
      8'd191: u = 8'h70;  8'd192: u = 8'h71;
      8'd193: u = 8'h72;  8'd194: u = 8'h73;
      default: u = 8'h00;
    endcase
    return u;
  endfunction

endpackage

[rtl/key_event_to_hid_report_switch_core.sv]
// ----------------------------------------------------------------------------
// key_event_to_hid_report_switch_core
// Builds HID boot keyboard reports from key events and switches between two
// targets on a double tap of a hotkey.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake            Payload
//  -------  ---  -------------------  ----------------------------------------------------
//  s_axis   in   tvalid/tready        tdata: key_code, event_time_ms; tuser: key_value
//  m_axis   out  tvalid/tready        tdata: modifier_bits, key_0..key_5; tuser: kind, target
//  cfg      in   cfg_valid/cfg_ready  cfg_addr: register index; cfg_data: value
//
// Flow: one event per cycle sustained while the output takes reports. An
// accepted event is registered in the lookup stage (registered read of the
// usage table), then resolved against the report state and, when a report
// is due, landed in the output register once that register is free.
// Reset: all control state, including the report and the hotkey tracker, clears at
// once; no clearing pass. Configuration resets to window 400, hotkey 70,
// both targets present.
// Stalls: a report waiting in the output register holds the lookup stage;
// the input takes an event whenever the lookup stage is empty or moves on in
// the same cycle. cfg_ready is always high.
// ----------------------------------------------------------------------------
module key_event_to_hid_report_switch_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [9:0] key_code, [41:10] event_time_ms, rest 0
  input  logic [1:0]  s_axis_tuser,   // [1:0] key_value

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [7:0] modifier_bits, [15:8] key_0 .. [55:48] key_5
  output logic [1:0]  m_axis_tuser,   // [0] report_kind, [1] target

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned CW = kehid_pkg::CODE_W;
  localparam int unsigned TW = kehid_pkg::TIME_W;
  localparam int unsigned WW = kehid_pkg::WINDOW_W;
  localparam int unsigned UW = kehid_pkg::USAGE_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [WW-1:0] tap_window_q;
  logic [CW-1:0] hotkey_q;
  logic [1:0]    present_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_window_q <= kehid_pkg::TAP_WINDOW_RST;
      hotkey_q     <= kehid_pkg::HOTKEY_RST;
      present_q    <= kehid_pkg::PRESENT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        kehid_pkg::CFG_TAP_WINDOW: tap_window_q <= cfg_data_i[WW-1:0];
        kehid_pkg::CFG_HOTKEY:     hotkey_q     <= cfg_data_i[CW-1:0];
        kehid_pkg::CFG_PRESENT:    present_q    <= cfg_data_i[1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Lookup stage: register the event and the usage table read
  // --------------------------------------------------------------------------
  logic          s1_valid_q;
  logic [CW-1:0] s1_code_q;
  logic [1:0]    s1_value_q;
  logic [TW-1:0] s1_time_q;
  logic [UW-1:0] s1_usage_q;

  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_fire       = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_code_q  <= s_axis_tdata[CW-1:0];
      s1_time_q  <= s_axis_tdata[CW+TW-1:CW];
      s1_value_q <= s_axis_tuser;
      s1_usage_q <= kehid_pkg::usage_of_code(s_axis_tdata[7:0]);
    end
  end

  // --------------------------------------------------------------------------
  // Report state and hotkey tracker
  // --------------------------------------------------------------------------
  kehid_pkg::phase_e phase_q, phase_d;
  logic [TW-1:0]     tap_start_q, tap_start_d;
  logic              target_q, target_d;
  logic [UW-1:0]     mask_q, mask_d;
  logic [UW-1:0]     slots_q [kehid_pkg::KEY_SLOTS];
  logic [UW-1:0]     slots_d [kehid_pkg::KEY_SLOTS];

  logic [TW-1:0] elapsed;
  logic          over_window;
  logic          under_window;
  logic          is_hotkey;
  logic          is_press;
  logic          is_switch;
  logic          drop_key;
  logic          done;
  logic          emit;
  logic          emit_kind;
  logic          emit_target;

  assign elapsed      = s1_time_q - tap_start_q;
  assign over_window  = elapsed > {{(TW-WW){1'b0}}, tap_window_q};
  assign under_window = elapsed < {{(TW-WW){1'b0}}, tap_window_q};
  assign is_hotkey    = s1_code_q == hotkey_q;
  assign is_press     = s1_value_q == kehid_pkg::KEY_PRESS;

  // Events that leave the report alone: repeats, codes past the table, and
  // codes that map to nothing.
  assign drop_key = (s1_value_q == kehid_pkg::KEY_REPEAT) || (s1_code_q[CW-1:8] != '0) ||
                    (s1_usage_q == '0);

  always_comb begin
    phase_d     = phase_q;
    tap_start_d = tap_start_q;
    target_d    = target_q;
    mask_d      = mask_q;
    slots_d     = slots_q;
    is_switch   = 1'b0;
    done        = 1'b0;
    emit        = 1'b0;
    emit_kind   = kehid_pkg::REPORT_KEY;
    emit_target = target_q;

    if (!is_hotkey) begin
      phase_d = kehid_pkg::PHASE_IDLE;
      if (!drop_key) begin
        if (s1_usage_q[UW-1:3] == kehid_pkg::MOD_USAGE_HI) begin
          mask_d[s1_usage_q[2:0]] = is_press;
        end else if (is_press) begin
          // take the first empty slot; drop the key when none is free
          for (int i = 0; i < kehid_pkg::KEY_SLOTS; i++) begin
            if (!done && slots_q[i] == '0) begin
              slots_d[i] = s1_usage_q;
              done       = 1'b1;
            end
          end
        end else begin
          // release clears the first matching slot
          for (int i = 0; i < kehid_pkg::KEY_SLOTS; i++) begin
            if (!done && slots_q[i] == s1_usage_q) begin
              slots_d[i] = '0;
              done       = 1'b1;
            end
          end
        end
        emit = present_q[target_q];
      end
    end else begin
      unique case (phase_q)
        kehid_pkg::PHASE_DOWN: begin
          if (s1_value_q == kehid_pkg::KEY_RELEASE) begin
            phase_d = kehid_pkg::PHASE_UP;
          end else if (over_window) begin
            phase_d = kehid_pkg::PHASE_IDLE;
          end
        end
        kehid_pkg::PHASE_UP: begin
          if (is_press && under_window) begin
            is_switch = 1'b1;
          end else if (over_window) begin
            phase_d = kehid_pkg::PHASE_IDLE;
          end
        end
        default: begin
          phase_d = kehid_pkg::PHASE_IDLE;
          if (is_press) begin
            tap_start_d = s1_time_q;
            phase_d     = kehid_pkg::PHASE_DOWN;
          end
        end
      endcase

      // Double tap: release everything at the old target, then toggle.
      if (is_switch) begin
        phase_d     = kehid_pkg::PHASE_IDLE;
        mask_d      = '0;
        for (int i = 0; i < kehid_pkg::KEY_SLOTS; i++) begin
          slots_d[i] = '0;
        end
        target_d    = !target_q;
        emit        = present_q[target_q];
        emit_kind   = kehid_pkg::REPORT_RELEASE_ALL;
        emit_target = target_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= kehid_pkg::PHASE_IDLE;
      tap_start_q <= '0;
      target_q    <= 1'b0;
      mask_q      <= '0;
      for (int i = 0; i < kehid_pkg::KEY_SLOTS; i++) begin
        slots_q[i] <= '0;
      end
    end else if (s1_fire) begin
      phase_q     <= phase_d;
      tap_start_q <= tap_start_d;
      target_q    <= target_d;
      mask_q      <= mask_d;
      slots_q     <= slots_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [kehid_pkg::OUT_DATA_W-1:0] out_data;

  // A release-all report carries an empty mask and empty slots, which is
  // exactly the cleared state written back on a switch.
  always_comb begin
    out_data         = '0;
    out_data[UW-1:0] = mask_d;
    for (int j = 0; j < kehid_pkg::SHOWN_SLOTS; j++) begin
      out_data[UW*(j+1) +: UW] = slots_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_axis_tvalid <= emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      m_axis_tdata <= out_data;
      m_axis_tuser <= {emit_target, emit_kind};
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_release_all_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[0] == kehid_pkg::REPORT_RELEASE_ALL) |->
      m_axis_tdata == '0)
    else $error("release-all report carries keys");

  a_switch_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && is_switch |=> target_q != $past(target_q))
    else $error("target did not toggle on switch");

  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without cause");

  a_key_report_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && emit && !is_switch |=> m_axis_tuser[1] == target_q)
    else $error("key report sent to wrong target");

endmodule
